[hw/rtl/bounded_double_ended_queue_top_macros.svh]
// assertion macros for the bounded double-ended queue
// used by bounded_double_ended_queue_top; expects clk_i and rst_ni in scope
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset only
`define BDEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset only
`define BDEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bdeq_pkg.sv]
// shared types and codes for the bounded double-ended queue
// no dependencies; used by bdeq_cell and bounded_double_ended_queue_top
package bdeq_pkg;

  // requested action of an input item
  typedef enum logic [2:0] {
    ACT_REPORT     = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_PUSH_FRONT = 3'd3,
    ACT_POP_FRONT  = 3'd4,
    ACT_CLEAR      = 3'd5
  } action_e;

  // result status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // operation broadcast to every cell of the row
  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_CLEAR      = 3'd5
  } cell_op_e;

endpackage

[hw/rtl/bdeq_cell.sv]
// one storage cell of the deque row: an element and a last-element marker
// depends on bdeq_pkg
module bdeq_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bdeq_pkg::cell_op_e    op_i,
  input  logic [DATA_WIDTH-1:0] push_value_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic                  left_tail_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  input  logic                  right_tail_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  tail_o,
  output logic [DATA_WIDTH-1:0] back_part_o,
  output logic [DATA_WIDTH-1:0] prev_part_o
);

  logic [DATA_WIDTH-1:0] data_d, data_q;
  logic                  tail_d, tail_q;

  always_comb begin
    data_d = data_q;
    tail_d = tail_q;
    case (op_i)
      bdeq_pkg::OP_PUSH_FRONT: begin
        data_d = left_data_i;
        tail_d = left_tail_i;
      end
      bdeq_pkg::OP_PUSH_BACK: begin
        // the cell right after the current last one takes the new item
        if (left_tail_i) begin
          data_d = push_value_i;
        end
        tail_d = left_tail_i;
      end
      bdeq_pkg::OP_POP_FRONT: begin
        data_d = right_data_i;
        tail_d = right_tail_i;
      end
      bdeq_pkg::OP_POP_BACK: begin
        tail_d = right_tail_i;
      end
      bdeq_pkg::OP_CLEAR: begin
        tail_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q <= 1'b0;
    end else begin
      tail_q <= tail_d;
    end
  end

  assign data_o      = data_q;
  assign tail_o      = tail_q;
  assign back_part_o = tail_q ? data_q : '0;
  assign prev_part_o = right_tail_i ? data_q : '0;

endmodule

[hw/rtl/bounded_double_ended_queue_top.sv]
// top level of the bounded double-ended queue: a row of bdeq_cell storage cells
// plus the action decoder and result register; depends on bdeq_pkg, bdeq_cell
// and bounded_double_ended_queue_top_macros.svh
//
// The deque keeps up to DEPTH elements in a row of cells, front element always
// in cell 0, so pushes and pops at the front shift the whole row by one cell,
// while back pushes and pops only move a one-hot marker that tags the last
// element. An item is taken when start_i is high and busy_o is low; busy_o
// is only high during reset and in the first cycle after it. Every item
// gives exactly one result in the next cycle, shown for one cycle with
// done_o high; the receiver cannot stall it, and a new item can be taken in
// every cycle, so the sustained rate is one item per clock. The result is
// held in the result register, which is written at the same edge as the
// cell row. Pops on an empty deque and pushes on a full one are refused
// with a status and leave the contents untouched.
module bounded_double_ended_queue_top #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item request
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [2:0]            action_i,
  input  logic [DATA_WIDTH-1:0] push_value_i,
  // result, one cycle wide
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [DATA_WIDTH-1:0] popped_value_o,
  output logic [DATA_WIDTH-1:0] front_value_o,
  output logic [DATA_WIDTH-1:0] back_value_o,
  output logic [CW-1:0]         occupancy_o
);

  `include "bounded_double_ended_queue_top_macros.svh"

  // cell row wiring
  logic [DATA_WIDTH-1:0] data_w      [DEPTH];
  logic [DATA_WIDTH-1:0] back_part_w [DEPTH];
  logic [DATA_WIDTH-1:0] prev_part_w [DEPTH];
  logic [DEPTH-1:0]      tail_w;

  logic [CW-1:0] count_d, count_q;
  logic          busy_q;
  logic          accept;
  logic          empty, full, multi;

  bdeq_pkg::cell_op_e op;
  bdeq_pkg::status_e  status_d;

  logic [DATA_WIDTH-1:0] cur_front, second, cur_back, prev_back;
  logic [DATA_WIDTH-1:0] popped_d, front_d, back_d;

  // registered result
  logic                  done_q;
  bdeq_pkg::status_e     status_q;
  logic [DATA_WIDTH-1:0] popped_q, front_q, back_q;
  logic [CW-1:0]         occ_q;

  assign accept = start_i && !busy_q;
  assign empty  = (count_q == '0);
  assign full   = (count_q == CW'(DEPTH));
  assign multi  = (count_q > CW'(1));

  // the row of cells; cell 0 sees the push value and the empty flag on its left
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data, right_data;
    logic                  left_tail, right_tail;

    if (i == 0) begin : g_first
      assign left_data = push_value_i;
      assign left_tail = empty;
    end else begin : g_inner_left
      assign left_data = data_w[i-1];
      assign left_tail = tail_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
      assign right_tail = 1'b0;
    end else begin : g_inner_right
      assign right_data = data_w[i+1];
      assign right_tail = tail_w[i+1];
    end

    bdeq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op),
      .push_value_i (push_value_i),
      .left_data_i  (left_data),
      .left_tail_i  (left_tail),
      .right_data_i (right_data),
      .right_tail_i (right_tail),
      .data_o       (data_w[i]),
      .tail_o       (tail_w[i]),
      .back_part_o  (back_part_w[i]),
      .prev_part_o  (prev_part_w[i])
    );
  end

  // last and second-to-last elements, picked by the one-hot marker
  always_comb begin
    cur_back  = '0;
    prev_back = '0;
    for (int i = 0; i < DEPTH; i++) begin
      cur_back  = cur_back | back_part_w[i];
      prev_back = prev_back | prev_part_w[i];
    end
  end

  assign cur_front = data_w[0];
  assign second    = data_w[1];

  // action decode and result values after the action
  always_comb begin
    op       = bdeq_pkg::OP_HOLD;
    status_d = bdeq_pkg::ST_OK;
    count_d  = count_q;
    popped_d = '0;
    front_d  = empty ? '0 : cur_front;
    back_d   = empty ? '0 : cur_back;
    case (action_i)
      bdeq_pkg::ACT_PUSH_BACK: begin
        if (full) begin
          status_d = bdeq_pkg::ST_FULL;
        end else begin
          op      = bdeq_pkg::OP_PUSH_BACK;
          count_d = count_q + CW'(1);
          front_d = empty ? push_value_i : cur_front;
          back_d  = push_value_i;
        end
      end
      bdeq_pkg::ACT_PUSH_FRONT: begin
        if (full) begin
          status_d = bdeq_pkg::ST_FULL;
        end else begin
          op      = bdeq_pkg::OP_PUSH_FRONT;
          count_d = count_q + CW'(1);
          front_d = push_value_i;
          back_d  = empty ? push_value_i : cur_back;
        end
      end
      bdeq_pkg::ACT_POP_BACK: begin
        if (empty) begin
          status_d = bdeq_pkg::ST_EMPTY;
        end else begin
          op       = bdeq_pkg::OP_POP_BACK;
          count_d  = count_q - CW'(1);
          popped_d = cur_back;
          front_d  = multi ? cur_front : '0;
          back_d   = multi ? prev_back : '0;
        end
      end
      bdeq_pkg::ACT_POP_FRONT: begin
        if (empty) begin
          status_d = bdeq_pkg::ST_EMPTY;
        end else begin
          op       = bdeq_pkg::OP_POP_FRONT;
          count_d  = count_q - CW'(1);
          popped_d = cur_front;
          front_d  = multi ? second : '0;
          back_d   = multi ? cur_back : '0;
        end
      end
      bdeq_pkg::ACT_CLEAR: begin
        op      = bdeq_pkg::OP_CLEAR;
        count_d = '0;
        front_d = '0;
        back_d  = '0;
      end
      default: begin
        // report only, unused codes included
      end
    endcase
    // nothing moves unless an item is taken
    if (!accept) begin
      op      = bdeq_pkg::OP_HOLD;
      count_d = count_q;
    end
  end

  // control state: count, busy after reset, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      busy_q  <= 1'b0;
      done_q  <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      popped_q <= popped_d;
      front_q  <= front_d;
      back_q   <= back_d;
      occ_q    <= count_d;
    end
  end

  assign busy_o         = busy_q;
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign front_value_o  = front_q;
  assign back_value_o   = back_q;
  assign occupancy_o    = occ_q;

  // marker sits on exactly one cell when the deque holds anything
  `BDEQ_ASSERT_NOW(a_tail_matches_count, 1'b1,
    $onehot0(tail_w) && ((count_q == '0) == (tail_w == '0)),
    "last-element marker disagrees with count")
  // count stays within the capacity
  `BDEQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH),
    "element count above capacity")
  // every taken item gives one result in the next cycle
  `BDEQ_ASSERT_NEXT(a_result_follows, accept, done_q && (occupancy_o == count_q),
    "result missing or occupancy out of step")
  // a refused item leaves the count alone
  `BDEQ_ASSERT_NEXT(a_refused_holds, accept && (status_d != bdeq_pkg::ST_OK),
    count_q == $past(count_q), "refused item changed the count")

endmodule

[tb/bounded_double_ended_queue_top_tb.sv]
// self-checking testbench for bounded_double_ended_queue_top: random and directed deque actions
// checked one by one against a behavioral deque kept in the bench
// depends on bdeq_pkg and the rtl of bounded_double_ended_queue_top
module bounded_double_ended_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdeq_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CW         = $clog2(DEPTH + 1);
  localparam int unsigned RAND_ITEMS = 750;
  localparam int unsigned QUIET_TAIL = 100;   // last items go out with no idling
  localparam logic [2:0]  ACT_SPARE6 = 3'd6;  // unused codes, behave as report
  localparam logic [2:0]  ACT_SPARE7 = 3'd7;
  localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;

  // one pending item, or a marker that makes the driver wait for all results
  typedef struct {
    logic [2:0]            act;
    logic [DATA_WIDTH-1:0] value;
    bit                    drain;
  } deque_req_t;

  typedef struct {
    status_e               status;
    logic [DATA_WIDTH-1:0] popped;
    logic [DATA_WIDTH-1:0] front;
    logic [DATA_WIDTH-1:0] back;
    logic [CW-1:0]         occ;
  } deque_resp_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic [2:0]            action_i = ACT_REPORT;
  logic [DATA_WIDTH-1:0] push_value_i = '0;
  logic                  busy_o;
  logic                  done_o;
  logic [1:0]            status_o;
  logic [DATA_WIDTH-1:0] popped_value_o;
  logic [DATA_WIDTH-1:0] front_value_o;
  logic [DATA_WIDTH-1:0] back_value_o;
  logic [CW-1:0]         occupancy_o;

  bounded_double_ended_queue_top #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .push_value_i   (push_value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow deque: ring of entries, head position and element count
  logic [DATA_WIDTH-1:0] shadow_ring [DEPTH];
  logic [3:0]            shadow_head = '0;
  logic [CW-1:0]         shadow_count = '0;

  deque_req_t  pending_items [$];
  deque_resp_t awaited_results [$];
  int unsigned items_total = 0;
  int unsigned items_taken = 0;
  int unsigned fail_count = 0;
  bit          taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned gap_pct = 20;

  // apply one action to the shadow deque and return the result it must produce
  function automatic deque_resp_t apply_action(logic [2:0] act, logic [DATA_WIDTH-1:0] value);
    deque_resp_t r;
    logic [3:0]  tail_pos;
    r.status = ST_OK;
    r.popped = '0;
    r.front  = '0;
    r.back   = '0;
    case (act)
      ACT_PUSH_BACK: begin
        if (shadow_count == CW'(DEPTH)) begin
          r.status = ST_FULL;
        end else begin
          tail_pos = shadow_head + shadow_count[3:0];
          shadow_ring[tail_pos] = value;
          shadow_count++;
        end
      end
      ACT_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          tail_pos = shadow_head + shadow_count[3:0] - 4'd1;
          r.popped = shadow_ring[tail_pos];
          shadow_count--;
        end
      end
      ACT_PUSH_FRONT: begin
        if (shadow_count == CW'(DEPTH)) begin
          r.status = ST_FULL;
        end else begin
          shadow_head = shadow_head - 4'd1;
          shadow_ring[shadow_head] = value;
          shadow_count++;
        end
      end
      ACT_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = shadow_ring[shadow_head];
          shadow_head = shadow_head + 4'd1;
          shadow_count--;
        end
      end
      ACT_CLEAR: begin
        shadow_head  = '0;
        shadow_count = '0;
      end
      default: ;  // report only, spare codes included
    endcase
    if (shadow_count != 0) begin
      tail_pos = shadow_head + shadow_count[3:0] - 4'd1;
      r.front  = shadow_ring[shadow_head];
      r.back   = shadow_ring[tail_pos];
    end
    r.occ = shadow_count;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [DATA_WIDTH-1:0] want,
                                        logic [DATA_WIDTH-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void queue_item(logic [2:0] act, logic [DATA_WIDTH-1:0] value);
    deque_req_t q;
    q.act   = act;
    q.value = value;
    q.drain = 1'b0;
    pending_items.push_back(q);
    items_total++;
  endfunction

  // sender waits here until every outstanding result is back
  function automatic void queue_drain();
    deque_req_t q;
    q.act   = ACT_REPORT;
    q.value = '0;
    q.drain = 1'b1;
    pending_items.push_back(q);
  endfunction

  // random action with a bias toward pushing or popping
  function automatic logic [2:0] pick_action(int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return ($urandom_range(0, 1) != 0) ? ACT_SPARE6 : ACT_SPARE7;
    if (roll < 5) return ACT_CLEAR;
    if (roll < 10) return ACT_REPORT;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return ($urandom_range(0, 1) != 0) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    return ($urandom_range(0, 1) != 0) ? ACT_POP_BACK : ACT_POP_FRONT;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES;
      default: return $urandom;
    endcase
  endfunction

  // monitor: check each result first, then log the item taken at this edge
  always @(posedge clk_i) begin
    deque_resp_t want;
    if (rst_ni) begin
      if (done_o !== 1'b0) begin
        if (awaited_results.size() == 0) begin
          $error("result strobe with no item outstanding");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", DATA_WIDTH'(want.status), DATA_WIDTH'(status_o));
          compare_field("popped_value", want.popped, popped_value_o);
          compare_field("front_value", want.front, front_value_o);
          compare_field("back_value", want.back, back_value_o);
          compare_field("occupancy", DATA_WIDTH'(want.occ), DATA_WIDTH'(occupancy_o));
        end
      end
      if (start_i && !busy_o) begin
        awaited_results.push_back(apply_action(action_i, push_value_i));
        items_taken++;
      end
    end
    taken <= rst_ni && start_i && !busy_o;
  end

  // driver: hold an offered item until taken, then send the next or idle a while
  always @(negedge clk_i) begin
    deque_req_t nxt;
    bit         offer;
    if (!(start_i && !taken)) begin
      offer = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_items.size() != 0) begin
        if (pending_items[0].drain) begin
          if (awaited_results.size() == 0) void'(pending_items.pop_front());
        end else if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 99) < gap_pct) begin
          gap_left = $urandom_range(0, 9);
        end else begin
          nxt   = pending_items.pop_front();
          offer = 1'b1;
          // now and then change how often the sender idles, zero included
          if ($urandom_range(0, 39) == 0) begin
            case ($urandom_range(0, 2))
              0:       gap_pct = 0;
              1:       gap_pct = 10;
              default: gap_pct = 35;
            endcase
          end
        end
      end
      if (offer) begin
        action_i     <= nxt.act;
        push_value_i <= nxt.value;
      end else begin
        // junk on the payload while idle must be ignored
        action_i     <= 3'($urandom);
        push_value_i <= $urandom;
      end
      start_i <= offer;
    end
  end

  initial begin
    int unsigned block_len;
    int unsigned push_pct;
    int unsigned since_drain;
    int unsigned spent;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed: empty deque, both pop errors, fill to full from both ends
    queue_item(ACT_REPORT, ALL_ONES);
    queue_item(ACT_POP_BACK, '0);
    queue_item(ACT_POP_FRONT, '0);
    queue_item(ACT_PUSH_BACK, '0);
    queue_item(ACT_PUSH_FRONT, ALL_ONES);
    for (int i = 2; i < DEPTH; i++) begin
      queue_item((i % 2 == 0) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, $urandom);
    end
    // push on full at either end is refused
    queue_item(ACT_PUSH_BACK, 32'h5a5a_5a5a);
    queue_item(ACT_PUSH_FRONT, 32'ha5a5_a5a5);
    queue_item(ACT_POP_BACK, '0);
    queue_item(ACT_POP_FRONT, '0);
    // spare codes act as report
    queue_item(ACT_SPARE6, ALL_ONES);
    queue_item(ACT_SPARE7, ALL_ONES);
    queue_item(ACT_CLEAR, '0);
    queue_drain();

    // random: blocks that lean toward filling, draining, or neither
    spent       = 0;
    since_drain = 0;
    while (spent < RAND_ITEMS) begin
      block_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      for (int i = 0; i < block_len && spent < RAND_ITEMS; i++) begin
        queue_item(pick_action(push_pct), pick_value());
        spent++;
        since_drain++;
      end
      // now and then let the pipe run empty before going on
      if (since_drain > 150 && spent < RAND_ITEMS - QUIET_TAIL) begin
        queue_drain();
        since_drain = 0;
      end
    end

    // all items in, all results back
    do @(negedge clk_i);
    while (items_taken != items_total || awaited_results.size() != 0);
    // then wait on the clock to catch any stray result
    repeat (4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/bdeq_pkg.sv
hw/rtl/bdeq_cell.sv
hw/rtl/bounded_double_ended_queue_top.sv
tb/bounded_double_ended_queue_top_tb.sv
